### rtl/core/pws_pkg.sv
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types and constants of the position-specific window scorer.
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int MAX_ROWS       = 256;
    localparam int ALPHABET_SLOTS = 32;

    localparam int COL_AW   = $clog2(ALPHABET_SLOTS);
    localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int TBL_AW   = ROW_AW + COL_AW;
    localparam int TBL_DEPTH = MAX_ROWS * (2 ** COL_AW);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);

    // Opcodes carried in the input tuser field.
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_SCORE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MOTIF_LENGTH = 1'b0;
    localparam logic CFG_SCORE_FLOOR  = 1'b1;

    localparam logic [8:0]         MOTIF_RESET = 9'd1;
    localparam logic signed [15:0] FLOOR_RESET = -16'sd32767;

    localparam logic signed [24:0] TOTAL_MAX = 25'sd8388607;
    localparam logic signed [24:0] TOTAL_MIN = -25'sd8388608;

    // Control of the accumulate stage.
    typedef struct packed {
        logic valid;
        logic score;
        logic restart;
        logic last;
        logic in_range;
    } t_s1_ctrl;

endpackage

### rtl/core/pws_ram.sv
// ----------------------------------------------------------------------------
// pws_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pws_accum.sv
// ----------------------------------------------------------------------------
// pws_accum
// Window accumulators (saturating total, zero-reset local run and its best)
// and the result register of the window scorer.
// ----------------------------------------------------------------------------
module pws_accum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pws_pkg::t_s1_ctrl      i_ctrl,
    input  logic signed [15:0]     i_entry,
    output logic                   o_go,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [23:0] window_total, [46:24] local_best, [47] zero
    output logic [47:0]            o_m_tdata
);
    import pws_pkg::*;

    logic signed [23:0] r_total, n_total;
    logic [22:0]        r_local, n_local;
    logic [22:0]        r_best, n_best;
    logic               r_out_valid;
    logic [46:0]        r_out_data;

    logic signed [24:0] entry_x;
    logic signed [24:0] sum_t;
    logic signed [24:0] sum_l;
    logic signed [23:0] tot_sat;
    logic [22:0]        loc_sat;
    logic [22:0]        best_upd;

    assign o_go = !r_out_valid || i_m_tready || !(i_ctrl.valid && i_ctrl.last);

    always_comb begin
        entry_x = i_ctrl.in_range ? 25'(i_entry) : 25'sd0;
        sum_t   = 25'(r_total) + entry_x;
        sum_l   = $signed({2'b00, r_local}) + entry_x;

        if (sum_t > TOTAL_MAX) begin
            tot_sat = TOTAL_MAX[23:0];
        end else if (sum_t < TOTAL_MIN) begin
            tot_sat = TOTAL_MIN[23:0];
        end else begin
            tot_sat = sum_t[23:0];
        end

        best_upd = r_best;
        if (sum_l[24]) begin
            loc_sat = '0;
        end else begin
            loc_sat = (sum_l > TOTAL_MAX) ? TOTAL_MAX[22:0] : sum_l[22:0];
            if (loc_sat > r_best) begin
                best_upd = loc_sat;
            end
        end

        n_total = r_total;
        n_local = r_local;
        n_best  = r_best;
        if (i_ctrl.valid && o_go) begin
            if (i_ctrl.restart || (i_ctrl.score && i_ctrl.last)) begin
                n_total = '0;
                n_local = '0;
                n_best  = '0;
            end else if (i_ctrl.score) begin
                n_total = tot_sat;
                n_local = loc_sat;
                n_best  = best_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_local     <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total <= n_total;
            r_local <= n_local;
            r_best  <= n_best;
            if (i_ctrl.valid && i_ctrl.score && i_ctrl.last && o_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid && i_ctrl.score && i_ctrl.last && o_go) begin
            r_out_data <= {best_upd, tot_sat};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_data};

endmodule

### rtl/core/pssm_window_scorer_unit.sv
// ----------------------------------------------------------------------------
// pssm_window_scorer_unit
// Position-specific score table with a streaming scoring window.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                 Content
//  s_*       in   s_tvalid / s_tready       table write, residue or restart
//  m_*       out  m_tvalid / m_tready       window total and best local score
//  cfg       in   i_cfg_valid / o_cfg_ready motif_length, score_floor
//
//  One item per cycle while s_tready is high; each residue costs one read of
//  the table RAM, whose registered data the accumulate stage uses. A result
//  is registered once that stage takes the item completing the window.
//  After reset a clearing pass writes zero to all TBL_DEPTH (8192) entries,
//  one per cycle; no item is taken during it, configuration writes are.
//  A result waiting in the output register stalls input only when the next
//  completed window would need that register.
// ----------------------------------------------------------------------------
module pssm_window_scorer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] row_index, [12:8] residue, [28:13] entry_value, [31:29] zero
    input  logic [31:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [23:0] window_total, [46:24] local_best, [47] zero
    output logic [47:0] m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pws_pkg::*;

    logic [8:0]          r_motif;
    logic signed [15:0]  r_floor;
    logic                r_clearing;
    logic [TBL_AW-1:0]   r_clr_addr;
    logic [CNT_W-1:0]    r_pos, n_pos;
    t_s1_ctrl            r_s1, n_s1;

    logic [7:0]          row;
    logic [4:0]          res;
    logic signed [15:0]  value;
    logic [1:0]          opcode;
    logic                accept;
    logic                go;
    logic [CNT_W-1:0]    win_len;
    logic [CNT_W:0]      pos_inc;
    logic                res_ok;
    logic                wr_hit;
    logic                rd_ok;
    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_waddr;
    logic [15:0]         tbl_wdata;
    logic [TBL_AW-1:0]   tbl_raddr;
    logic [15:0]         tbl_rdata;

    assign row    = s_tdata[7:0];
    assign res    = s_tdata[12:8];
    assign value  = s_tdata[28:13];
    assign opcode = s_tuser;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !r_clearing && (!r_s1.valid || go);
    assign accept      = s_tvalid && s_tready;

    always_comb begin
        if (r_motif == 9'd0) begin
            win_len = CNT_W'(1);
        end else if (32'(r_motif) > MAX_ROWS) begin
            win_len = CNT_W'(MAX_ROWS);
        end else begin
            win_len = CNT_W'(r_motif);
        end
    end

    assign res_ok  = 32'(res) < ALPHABET_SLOTS;
    assign wr_hit  = (32'(row) < 32'(win_len)) && res_ok;
    assign rd_ok   = (32'(r_pos) < MAX_ROWS) && res_ok;
    assign pos_inc = {1'b0, r_pos} + 1'b1;

    always_comb begin
        n_pos = r_pos;
        n_s1  = '0;
        if (accept) begin
            n_s1.valid = 1'b1;
            case (opcode)
                OP_SCORE: begin
                    n_s1.score    = 1'b1;
                    n_s1.in_range = rd_ok;
                    if (pos_inc >= {1'b0, win_len}) begin
                        n_s1.last = 1'b1;
                        n_pos     = '0;
                    end else begin
                        n_pos = pos_inc[CNT_W-1:0];
                    end
                end
                OP_RESTART: begin
                    n_s1.restart = 1'b1;
                    n_pos        = '0;
                end
                default: begin
                end
            endcase
        end else if (!go) begin
            n_s1 = r_s1;
        end
    end

    // Table port usage: clearing pass, floored writes, residue reads.
    always_comb begin
        if (r_clearing) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_addr;
            tbl_wdata = '0;
        end else begin
            tbl_we    = accept && (opcode == OP_WRITE) && wr_hit;
            tbl_waddr = {ROW_AW'(row), COL_AW'(res)};
            tbl_wdata = (value < r_floor) ? r_floor : value;
        end
    end

    assign tbl_raddr = {ROW_AW'(r_pos), COL_AW'(res)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif    <= MOTIF_RESET;
            r_floor    <= FLOOR_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_pos      <= '0;
            r_s1       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MOTIF_LENGTH: r_motif <= i_cfg_data[8:0];
                    CFG_SCORE_FLOOR:  r_floor <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (32'(r_clr_addr) == TBL_DEPTH - 1) begin
                    r_clearing <= 1'b0;
                end
            end
            r_pos <= n_pos;
            r_s1  <= n_s1;
        end
    end

    pws_ram #(
        .WIDTH (16),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (accept && (opcode == OP_SCORE) && rd_ok),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    pws_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (r_s1),
        .i_entry    ($signed(tbl_rdata)),
        .o_go       (go),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule

### sim/pssm_window_scorer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssm_window_scorer_unit_tb
// Self-checking bench for the position-specific window scorer. Table writes,
// residues and restarts go in over the input stream in random bursts. A
// scoring model inside the bench tracks the table and the window and queues
// the expected window results. Each output transaction is compared field by
// field against the oldest queued result while the output side stalls at
// random when stalls are enabled.
// ----------------------------------------------------------------------------
module pssm_window_scorer_unit_tb;

    import pws_pkg::*;

    localparam logic [1:0] OP_IDLE = 2'd3;  // unused opcode, must be a no-op
    localparam int         NUM_CELLS = MAX_ROWS * ALPHABET_SLOTS;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         row;
        logic [4:0]         res;
        logic signed [15:0] value;
    } t_seq_item;

    typedef struct {
        logic signed [23:0] total;
        logic [22:0]        best;
    } t_window_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    // Scoring model state.
    logic signed [15:0] score_tbl [NUM_CELLS];
    int                 win_pos, win_total, win_local, win_best;
    logic [8:0]         cfg_motif;
    logic signed [15:0] cfg_floor;
    t_window_result     pending_windows [$];

    int error_count = 0;
    int burst_left = 0;
    int stall_left = 0;
    bit sender_gaps = 1'b0;
    bit receiver_stalls = 1'b0;

    pssm_window_scorer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int window_length();
        if (cfg_motif == 0) return 1;
        if (cfg_motif > MAX_ROWS) return MAX_ROWS;
        return int'(cfg_motif);
    endfunction

    function automatic void clear_window();
        win_pos   = 0;
        win_total = 0;
        win_local = 0;
        win_best  = 0;
    endfunction

    // Advances the model by one accepted item and queues a result when the
    // window completes.
    function automatic void score_item(input t_seq_item it);
        int eff_len;
        int entry;
        int pos;
        eff_len = window_length();
        case (it.op)
            OP_WRITE: begin
                if (it.row < eff_len && it.res < ALPHABET_SLOTS)
                    score_tbl[it.row * ALPHABET_SLOTS + it.res] =
                        (it.value < cfg_floor) ? cfg_floor : it.value;
            end
            OP_RESTART: clear_window();
            OP_SCORE: begin
                pos   = win_pos;
                entry = 0;
                if (pos < MAX_ROWS && it.res < ALPHABET_SLOTS)
                    entry = score_tbl[pos * ALPHABET_SLOTS + it.res];
                win_total = win_total + entry;
                if (win_total > TOTAL_MAX) win_total = TOTAL_MAX;
                if (win_total < TOTAL_MIN) win_total = TOTAL_MIN;
                win_local = win_local + entry;
                if (win_local < 0) begin
                    win_local = 0;
                end else begin
                    if (win_local > TOTAL_MAX) win_local = TOTAL_MAX;
                    if (win_local > win_best) win_best = win_local;
                end
                win_pos = (pos + 1) % 512;
                if (pos + 1 >= eff_len) begin
                    pending_windows.push_back('{total: win_total[23:0],
                                               best: win_best[22:0]});
                    clear_window();
                end
            end
            default: ;
        endcase
    endfunction

    // Sends one item, with random gaps between bursts when enabled.
    task automatic send_item(input logic [1:0] op, input logic [7:0] row,
                             input logic [4:0] res, input logic signed [15:0] value);
        t_seq_item it;
        int gap;
        it = '{op: op, row: row, res: res, value: value};
        if (burst_left == 0) begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, value, res, row};
        do @(posedge i_clk); while (!s_tready);
        score_item(it);
        burst_left--;
    endtask

    task automatic write_register(input logic idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MOTIF_LENGTH) cfg_motif = data[8:0];
        else cfg_floor = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every queued result has come out and the pipeline is empty.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_windows.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] random_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 100)) - 16'sd50;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output checker and ready pattern.
    always @(posedge i_clk) begin
        t_window_result want;
        logic signed [23:0] got_total;
        logic [22:0] got_best;
        if (i_rst_n && m_tvalid && m_tready) begin
            got_total = m_tdata[23:0];
            got_best  = m_tdata[46:24];
            if (pending_windows.size() == 0) begin
                $display("%0t: unexpected result: window_total %0d, local_best %0d",
                         $time, got_total, got_best);
                error_count++;
            end else begin
                want = pending_windows.pop_front();
                if (got_total !== want.total) begin
                    $display("%0t: window_total mismatch: expected %0d, actual %0d",
                             $time, want.total, got_total);
                    error_count++;
                end
                if (got_best !== want.best) begin
                    $display("%0t: local_best mismatch: expected %0d, actual %0d",
                             $time, want.best, got_best);
                    error_count++;
                end
            end
        end
        if (!receiver_stalls) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Register defaults: a length of one and a floor of -32767.
    task automatic test_reset_defaults();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        send_item(OP_WRITE, 8'd0, 5'd5, 16'sh8000);
        send_item(OP_WRITE, 8'd1, 5'd0, 16'sd500);
        send_item(OP_SCORE, 8'd0, 5'd5, 16'sd0);
        send_item(OP_IDLE, 8'hFF, 5'd31, 16'shFFFF);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
    endtask

    task automatic test_directed_entries();
        drain_pipeline();
        write_register(CFG_SCORE_FLOOR, 16'h8000);
        write_register(CFG_MOTIF_LENGTH, 16'd4);
        send_item(OP_WRITE, 8'd0, 5'd31, 16'sh7FFF);
        send_item(OP_WRITE, 8'd1, 5'd0, 16'sh8000);
        send_item(OP_WRITE, 8'd2, 5'd17, 16'sd100);
        send_item(OP_WRITE, 8'd3, 5'd10, -16'sd5);
        send_item(OP_WRITE, 8'd4, 5'd1, 16'sd77);
        send_item(OP_WRITE, 8'd0, 5'd0, 16'sh8000);
        send_item(OP_SCORE, 8'd0, 5'd31, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd17, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd10, 16'sd0);
        // A restart in the middle drops the partial window.
        send_item(OP_SCORE, 8'd0, 5'd31, 16'sd0);
        send_item(OP_RESTART, 8'd0, 5'd0, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd31, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd17, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd10, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        send_item(OP_IDLE, 8'd0, 5'd0, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
    endtask

    task automatic test_window_length();
        drain_pipeline();
        send_item(OP_SCORE, 8'd0, 5'd31, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        // Lowering the length to no more than the current position closes the window
        // on the next residue.
        drain_pipeline();
        write_register(CFG_MOTIF_LENGTH, 16'd2);
        send_item(OP_SCORE, 8'd0, 5'd17, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd31, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd0, 16'sd0);
        drain_pipeline();
        write_register(CFG_MOTIF_LENGTH, 16'd0);
        send_item(OP_WRITE, 8'd1, 5'd3, 16'sd9);
        send_item(OP_SCORE, 8'd0, 5'd31, 16'sd0);
        send_item(OP_SCORE, 8'd0, 5'd3, 16'sd0);
        drain_pipeline();
        write_register(CFG_MOTIF_LENGTH, 16'hFFFF);
        write_register(CFG_SCORE_FLOOR, -16'sd1000);
        send_item(OP_WRITE, 8'd255, 5'd12, -16'sd1234);
    endtask

    // Full-length windows at both ends of the entry range.
    task automatic test_full_window();
        drain_pipeline();
        write_register(CFG_MOTIF_LENGTH, 16'd256);
        write_register(CFG_SCORE_FLOOR, 16'h8000);
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        for (int r = 0; r < MAX_ROWS; r++) begin
            send_item(OP_WRITE, 8'(r), 5'd31, 16'sh7FFF);
            send_item(OP_WRITE, 8'(r), 5'd0, 16'sh8000);
        end
        repeat (MAX_ROWS) send_item(OP_SCORE, 8'($urandom), 5'd31, 16'($urandom));
        repeat (MAX_ROWS) send_item(OP_SCORE, 8'($urandom), 5'd0, 16'($urandom));
    endtask

    task automatic test_random_windows();
        int lengths [12] = '{1, 2, 3, 5, 0, 8, 4, 300, 6, 16, 2, 7};
        int eff_len;
        int pick;
        logic [7:0] row;
        logic [4:0] res;
        for (int ph = 0; ph < 12; ph++) begin
            drain_pipeline();
            write_register(CFG_MOTIF_LENGTH, {7'($urandom), 9'(lengths[ph])});
            case ($urandom_range(0, 2))
                0: write_register(CFG_SCORE_FLOOR, 16'h0000);
                1: write_register(CFG_SCORE_FLOOR, 16'h8000);
                default: write_register(CFG_SCORE_FLOOR, -16'($urandom_range(0, 32767)));
            endcase
            sender_gaps = (ph % 3) != 0;
            receiver_stalls = (ph % 4) != 1;
            eff_len = window_length();
            repeat (15) begin
                pick = $urandom_range(0, 99);
                res = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
                if (pick < 30) begin
                    row = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, eff_len - 1))
                                                      : 8'($urandom);
                    send_item(OP_WRITE, row, res, random_value());
                end else if (pick < 94) begin
                    send_item(OP_SCORE, 8'($urandom), res, 16'($urandom));
                end else if (pick < 97) begin
                    send_item(OP_RESTART, 8'($urandom), res, 16'($urandom));
                end else begin
                    send_item(OP_IDLE, 8'($urandom), res, 16'($urandom));
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_CELLS; i++) score_tbl[i] = '0;
        clear_window();
        cfg_motif = MOTIF_RESET;
        cfg_floor = FLOOR_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_entries();
        test_window_length();
        test_full_window();
        test_random_windows();
        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
